@@ rtl/rtu_request_frame_check_top_macros.svh @@
// ----------------------------------------------------------------------------
// RTU request frame check assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RTU_REQUEST_FRAME_CHECK_TOP_MACROS_SVH
`define RTU_REQUEST_FRAME_CHECK_TOP_MACROS_SVH

`ifndef SYNTH
`define RFC_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rtu frame check assertion failed");
`define RFC_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("rtu frame check assertion failed");
`else
`define RFC_ASSERT(name, clk, rst_n, prop)
`define RFC_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ rtl/rtu_rfc_pkg.sv @@
// ----------------------------------------------------------------------------
// RTU request frame check package
// Request and response types, status and register codes, CRC byte update.
// ----------------------------------------------------------------------------
package rtu_rfc_pkg;

    localparam int SLOTS_PER_BUS_DEF = 32;

    localparam logic [2:0] ST_GET     = 3'd0;
    localparam logic [2:0] ST_SET     = 3'd1;
    localparam logic [2:0] ST_BADLEN  = 3'd2;
    localparam logic [2:0] ST_BADCRC  = 3'd3;
    localparam logic [2:0] ST_RANGE   = 3'd4;
    localparam logic [2:0] ST_UNKNOWN = 3'd5;

    localparam logic [1:0] CFG_BUS_COUNT = 2'd0;
    localparam logic [1:0] CFG_BOX_COUNT = 2'd1;
    localparam logic [1:0] CFG_GET_CODE  = 2'd2;
    localparam logic [1:0] CFG_SET_CODE  = 2'd3;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [3:0] CNT_MAX   = 4'd15;
    localparam logic [3:0] HDR_BYTES = 4'd6;
    localparam logic [3:0] POS_CRC_LO = 4'd6;
    localparam logic [3:0] POS_CRC_HI = 4'd7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } t_req;

    typedef struct packed {
        logic [7:0]  station;
        logic [7:0]  func_code;
        logic [15:0] position;
        logic [15:0] value;
        logic [2:0]  bus_index;
        logic [4:0]  slot;
        logic [2:0]  status;
    } t_rsp;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/rtu_request_frame_check_top.sv @@
// ----------------------------------------------------------------------------
// RTU request frame check
// Byte-wide CRC-16 check and field decode of eight-byte request frames.
//
// Channel   Dir  Handshake                     Payload
// in        in   i_in_valid / o_in_ready       i_in_req  (t_req)
// out       out  o_out_valid / i_out_ready     o_out_rsp (t_rsp)
// cfg       in   i_cfg_we                      i_cfg_idx, i_cfg_wdata
//
// One request byte per cycle; the CRC update and decode sit between the frame
// state registers and the response register. The response is valid in the cycle
// after the last byte is accepted. Input stalls only while a response waits
// and the output is not ready. Reset is synchronous and clears the frame
// state, the response valid and the registers to their defaults.
// ----------------------------------------------------------------------------
module rtu_request_frame_check_top
    import rtu_rfc_pkg::*;
#(
    parameter int SLOTS_PER_BUS = SLOTS_PER_BUS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_req       i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_rsp       o_out_rsp,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata
);

`include "rtu_request_frame_check_top_macros.svh"

    logic [3:0]  r_bus_count;
    logic [5:0]  r_box_count;
    logic [7:0]  r_get_code;
    logic [7:0]  r_set_code;

    logic [15:0] r_crc,   n_crc;
    logic [3:0]  r_cnt,   n_cnt;
    logic [47:0] r_hdr,   n_hdr;
    logic [7:0]  r_crc_lo, n_crc_lo;

    logic        r_out_valid, n_out_valid;
    t_rsp        r_rsp, n_rsp;

    logic        in_acc;
    logic        frame_done;
    logic        byte_adv;
    logic        crc_ok;
    logic        len_ok;
    logic        out_range;
    logic [7:0]  quot;
    logic [7:0]  rem;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign frame_done  = in_acc && i_in_req.frame_end;
    assign byte_adv    = in_acc && !i_in_req.frame_end;
    assign n_out_valid = frame_done || (r_out_valid && !i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bus_count <= 4'd8;
            r_box_count <= 6'd32;
            r_get_code  <= 8'd3;
            r_set_code  <= 8'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BUS_COUNT: r_bus_count <= i_cfg_wdata[3:0];
                CFG_BOX_COUNT: r_box_count <= i_cfg_wdata[5:0];
                CFG_GET_CODE:  r_get_code  <= i_cfg_wdata;
                CFG_SET_CODE:  r_set_code  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_hdr    = r_hdr;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        crc_ok   = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (r_cnt == 4'(i)) begin
                n_hdr[8*(5-i) +: 8] = i_in_req.data_byte;
            end
        end
        if (r_cnt < HDR_BYTES) begin
            n_crc = crc_feed(r_crc, i_in_req.data_byte);
        end else if (r_cnt == POS_CRC_LO) begin
            n_crc_lo = i_in_req.data_byte;
        end else if (r_cnt == POS_CRC_HI) begin
            crc_ok = (r_crc_lo == r_crc[7:0]) && (i_in_req.data_byte == r_crc[15:8]);
        end
        n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + 4'd1;
    end

    rtu_rfc_split #(
        .SLOTS_PER_BUS(SLOTS_PER_BUS)
    ) u_split (
        .i_station (n_hdr[47:40]),
        .o_quot    (quot),
        .o_rem     (rem)
    );

    assign len_ok    = (r_cnt == POS_CRC_HI);
    assign out_range = (quot >= {4'd0, r_bus_count}) || (rem == 8'd0)
                       || (rem >= {2'd0, r_box_count});

    always_comb begin
        n_rsp.station   = n_hdr[47:40];
        n_rsp.func_code = n_hdr[39:32];
        n_rsp.position  = n_hdr[31:16];
        n_rsp.value     = n_hdr[15:0];
        n_rsp.bus_index = (quot > 8'd7) ? 3'd7 : quot[2:0];
        n_rsp.slot      = rem[4:0];
        if (!len_ok) begin
            n_rsp.status = ST_BADLEN;
        end else if (!crc_ok) begin
            n_rsp.status = ST_BADCRC;
        end else if (out_range) begin
            n_rsp.status = ST_RANGE;
        end else if (n_hdr[39:32] == r_get_code) begin
            n_rsp.status = ST_GET;
        end else if (n_hdr[39:32] == r_set_code) begin
            n_rsp.status = ST_SET;
        end else begin
            n_rsp.status = ST_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= CRC_INIT;
            r_cnt       <= '0;
            r_hdr       <= '0;
            r_crc_lo    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_acc) begin
                if (i_in_req.frame_end) begin
                    r_crc    <= CRC_INIT;
                    r_cnt    <= '0;
                    r_hdr    <= '0;
                    r_crc_lo <= '0;
                end else begin
                    r_crc    <= n_crc;
                    r_cnt    <= n_cnt;
                    r_hdr    <= n_hdr;
                    r_crc_lo <= n_crc_lo;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (frame_done) begin
            r_rsp <= n_rsp;
        end
    end

    `RFC_ASSERT(a_cnt_clear, i_clk, i_rst_n, frame_done |=> (r_cnt == 4'd0))
    `RFC_ASSERT(a_crc_clear, i_clk, i_rst_n, frame_done |=> (r_crc == CRC_INIT))
    `RFC_ASSERT(a_cnt_sat, i_clk, i_rst_n, (byte_adv && r_cnt == CNT_MAX) |=> (r_cnt == CNT_MAX))
    `RFC_ASSERT(a_rsp_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(frame_done))
    `RFC_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !r_out_valid)

endmodule

@@ rtl/rtu_rfc_split.sv @@
// ----------------------------------------------------------------------------
// RTU station split
// Splits a station address into bus index and slot by constant lookup tables.
// ----------------------------------------------------------------------------
module rtu_rfc_split
    import rtu_rfc_pkg::*;
#(
    parameter int SLOTS_PER_BUS = SLOTS_PER_BUS_DEF
) (
    input  logic [7:0] i_station,
    output logic [7:0] o_quot,
    output logic [7:0] o_rem
);

    logic [7:0] quot_tab [256];
    logic [7:0] rem_tab  [256];

    for (genvar k = 0; k < 256; k++) begin : g_tab
        assign quot_tab[k] = 8'(k / SLOTS_PER_BUS);
        assign rem_tab[k]  = 8'(k % SLOTS_PER_BUS);
    end

    assign o_quot = quot_tab[i_station];
    assign o_rem  = rem_tab[i_station];

endmodule
